### sv/angular_segment_colour_map_macros.svh
// Assertion macros used by the checker of the angular segment colour map.
`ifndef ANGULAR_SEGMENT_COLOUR_MAP_MACROS_SVH
`define ANGULAR_SEGMENT_COLOUR_MAP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/asc_pkg.sv
// Types, constants and tables of the angular segment colour map.
package asc_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int MAX_DIM      = 4096;
	localparam int PX_W         = 46;
	localparam int CN_W         = 22;

	// register indexes of the configuration port
	localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [2:0] REG_SEGMENTS  = 3'd2;
	localparam logic [2:0] REG_CLOCKWISE = 3'd3;
	localparam logic [2:0] REG_CORNER    = 3'd4;
	localparam logic [2:0] REG_WIDTH     = 3'd5;
	localparam logic [2:0] REG_HEIGHT    = 3'd6;

	// corner codes
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	typedef struct packed {
		logic [16:0] centre_x;
		logic [16:0] centre_y;
		logic [10:0] segmentation;
		logic        clockwise;
		logic [2:0]  corner_pick;
		logic [12:0] frame_width;
		logic [12:0] frame_height;
	} asc_cfg_t;

	// one word in flight through the rotation chain: pixel lane and corner lane
	typedef struct packed {
		logic                   vld;
		logic signed [PX_W-1:0] px;
		logic signed [PX_W-1:0] py;
		logic [31:0]            pz;
		logic signed [CN_W-1:0] cx;
		logic signed [CN_W-1:0] cy;
		logic [31:0]            cz;
		logic                   cw;
		logic [10:0]            n;
	} asc_word_t;

	function automatic logic [31:0] asc_atan(input logic [4:0] i);
		case (i)
			5'd0:  asc_atan = 32'h20000000;
			5'd1:  asc_atan = 32'h12E4051D;
			5'd2:  asc_atan = 32'h09FB385B;
			5'd3:  asc_atan = 32'h051111D4;
			5'd4:  asc_atan = 32'h028B0D43;
			5'd5:  asc_atan = 32'h0145D7E1;
			5'd6:  asc_atan = 32'h00A2F61E;
			5'd7:  asc_atan = 32'h00517C55;
			5'd8:  asc_atan = 32'h0028BE53;
			5'd9:  asc_atan = 32'h00145F2F;
			5'd10: asc_atan = 32'h000A2F98;
			5'd11: asc_atan = 32'h000517CC;
			5'd12: asc_atan = 32'h00028BE6;
			5'd13: asc_atan = 32'h000145F3;
			5'd14: asc_atan = 32'h0000A2F9;
			5'd15: asc_atan = 32'h0000517C;
			5'd16: asc_atan = 32'h000028BE;
			5'd17: asc_atan = 32'h0000145F;
			5'd18: asc_atan = 32'h00000A2F;
			5'd19: asc_atan = 32'h00000517;
			5'd20: asc_atan = 32'h0000028B;
			5'd21: asc_atan = 32'h00000145;
			5'd22: asc_atan = 32'h000000A2;
			5'd23: asc_atan = 32'h00000051;
			5'd24: asc_atan = 32'h00000028;
			5'd25: asc_atan = 32'h00000014;
			5'd26: asc_atan = 32'h0000000A;
			5'd27: asc_atan = 32'h00000005;
			5'd28: asc_atan = 32'h00000002;
			5'd29: asc_atan = 32'h00000001;
			default: asc_atan = 32'h00000000;
		endcase
	endfunction

	function automatic logic [23:0] asc_palette(input logic [5:0] c);
		case (c)
			6'd0:  asc_palette = 24'h00FF00;
			6'd1:  asc_palette = 24'h0000FF;
			6'd2:  asc_palette = 24'hFF0000;
			6'd3:  asc_palette = 24'h01FFFE;
			6'd4:  asc_palette = 24'hFFA6FE;
			6'd5:  asc_palette = 24'hFFDB66;
			6'd6:  asc_palette = 24'h006401;
			6'd7:  asc_palette = 24'h010067;
			6'd8:  asc_palette = 24'h95003A;
			6'd9:  asc_palette = 24'h007DB5;
			6'd10: asc_palette = 24'hFF00F6;
			6'd11: asc_palette = 24'hFFEEE8;
			6'd12: asc_palette = 24'h774D00;
			6'd13: asc_palette = 24'h90FB92;
			6'd14: asc_palette = 24'h0076FF;
			6'd15: asc_palette = 24'hD5FF00;
			6'd16: asc_palette = 24'hFF937E;
			6'd17: asc_palette = 24'h6A826C;
			6'd18: asc_palette = 24'hFF029D;
			6'd19: asc_palette = 24'hFE8900;
			6'd20: asc_palette = 24'h7A4782;
			6'd21: asc_palette = 24'h7E2DD2;
			6'd22: asc_palette = 24'h85A900;
			6'd23: asc_palette = 24'hFF0056;
			6'd24: asc_palette = 24'hA42400;
			6'd25: asc_palette = 24'h00AE7E;
			6'd26: asc_palette = 24'h683D3B;
			6'd27: asc_palette = 24'hBDC6FF;
			6'd28: asc_palette = 24'h263400;
			6'd29: asc_palette = 24'hBDD393;
			6'd30: asc_palette = 24'h00B917;
			6'd31: asc_palette = 24'h9E008E;
			6'd32: asc_palette = 24'h001544;
			6'd33: asc_palette = 24'hC28C9F;
			6'd34: asc_palette = 24'hFF74A3;
			6'd35: asc_palette = 24'h01D0FF;
			6'd36: asc_palette = 24'h004754;
			6'd37: asc_palette = 24'hE56FFE;
			6'd38: asc_palette = 24'h788231;
			6'd39: asc_palette = 24'h0E4CA1;
			6'd40: asc_palette = 24'h91D0CB;
			6'd41: asc_palette = 24'hBE9970;
			6'd42: asc_palette = 24'h968AE8;
			6'd43: asc_palette = 24'hBB8800;
			6'd44: asc_palette = 24'h43002C;
			6'd45: asc_palette = 24'hDEFF74;
			6'd46: asc_palette = 24'h00FFC6;
			6'd47: asc_palette = 24'hFFE502;
			6'd48: asc_palette = 24'h620E00;
			6'd49: asc_palette = 24'h008F9C;
			6'd50: asc_palette = 24'h98FF52;
			6'd51: asc_palette = 24'h7544B1;
			6'd52: asc_palette = 24'hB500FF;
			6'd53: asc_palette = 24'h00FF78;
			6'd54: asc_palette = 24'hFF6E41;
			6'd55: asc_palette = 24'h005F39;
			6'd56: asc_palette = 24'h6B6882;
			6'd57: asc_palette = 24'h5FAD4E;
			6'd58: asc_palette = 24'hA75740;
			6'd59: asc_palette = 24'hA5FFD2;
			6'd60: asc_palette = 24'hFFB167;
			6'd61: asc_palette = 24'h009BFF;
			6'd62: asc_palette = 24'hE85EBE;
			default: asc_palette = 24'h000000;
		endcase
	endfunction

endpackage

### sv/asc_front.sv
// Front end: offsets, scaling, reference corner choice and half-plane fold.
module asc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [11:0]       pixel_x,
	input  logic [11:0]       pixel_y,
	input  asc_pkg::asc_cfg_t cfg,
	output asc_pkg::asc_word_t dout
);
	import asc_pkg::*;

	logic [12:0]        wc, hc;
	logic [29:0]        mx, my;
	logic signed [30:0] dx, dy;
	logic signed [18:0] gx, gy, bd;
	logic signed [18:0] sc [4];
	logic [1:0]         best, idx, step;
	logic signed [CN_W-1:0] cvx, cvy;

	logic               vld_s1, cw_s1;
	logic [10:0]        n_s1;
	logic [12:0]        w_s1, h_s1;
	logic signed [30:0] dx_s1, dy_s1;
	logic signed [CN_W-1:0] cvx_s1, cvy_s1;

	logic               vld_s2, cw_s2;
	logic [10:0]        n_s2;
	logic signed [44:0] x_s2, y_s2;
	logic signed [CN_W-1:0] cvx_s2, cvy_s2;

	logic [PX_W-1:0]    xm, ym;

	always_comb begin
		wc = cfg.frame_width;
		if (cfg.frame_width == 13'd0) wc = 13'd1;
		else if (cfg.frame_width > 13'(MAX_DIM)) wc = 13'(MAX_DIM);
		hc = cfg.frame_height;
		if (cfg.frame_height == 13'd0) hc = 13'd1;
		else if (cfg.frame_height > 13'(MAX_DIM)) hc = 13'(MAX_DIM);
		mx = 30'(cfg.centre_x) * 30'(wc);
		my = 30'(cfg.centre_y) * 30'(hc);
		dx = $signed({3'b000, pixel_x, 16'h0000}) - $signed({1'b0, mx});
		dy = $signed({3'b000, pixel_y, 16'h0000}) - $signed({1'b0, my});
	end

	// corner distance squared differs by 2^17 times a linear score
	always_comb begin
		gx = $signed({2'b00, cfg.centre_x}) - 19'sd32768;
		gy = $signed({2'b00, cfg.centre_y}) - 19'sd32768;
		sc[CORNER_TL] = gx + gy;
		sc[CORNER_TR] = gy;
		sc[CORNER_BR] = 19'sd0;
		sc[CORNER_BL] = gx;
		step = cfg.corner_pick[2] ? 2'd3 : 2'd1;
		best = cfg.corner_pick[1:0];
		idx  = cfg.corner_pick[1:0];
		bd   = sc[best];
		for (int k = 0; k < 3; k++) begin
			idx = idx + step;
			if (sc[idx] > bd) begin
				bd   = sc[idx];
				best = idx;
			end
		end
		if (best == CORNER_TR || best == CORNER_BR)
			cvx = 22'sd65536 - $signed({5'b00000, cfg.centre_x});
		else
			cvx = -$signed({5'b00000, cfg.centre_x});
		if (best == CORNER_BR || best == CORNER_BL)
			cvy = 22'sd65536 - $signed({5'b00000, cfg.centre_y});
		else
			cvy = -$signed({5'b00000, cfg.centre_y});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cw_s1  <= cfg.clockwise;
			n_s1   <= (cfg.segmentation == 11'd0) ? 11'd1 : cfg.segmentation;
			w_s1   <= wc;
			h_s1   <= hc;
			dx_s1  <= dx;
			dy_s1  <= dy;
			cvx_s1 <= cvx;
			cvy_s1 <= cvy;

			cw_s2  <= cw_s1;
			n_s2   <= n_s1;
			x_s2   <= dx_s1 * $signed({1'b0, h_s1});
			y_s2   <= dy_s1 * $signed({1'b0, w_s1});
			cvx_s2 <= cvx_s1;
			cvy_s2 <= cvy_s1;
		end
	end

	always_comb begin
		xm = PX_W'(x_s2);
		ym = PX_W'(y_s2);
	end

	// fold the left half plane onto the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dout   <= '0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			dout.vld <= vld_s2;
			if (x_s2 < 0) begin
				dout.px <= -$signed(xm);
				dout.py <= -$signed(ym);
				dout.pz <= 32'h80000000;
			end else begin
				dout.px <= $signed(xm);
				dout.py <= $signed(ym);
				dout.pz <= 32'h00000000;
			end
			if (cvx_s2 < 0) begin
				dout.cx <= -cvx_s2;
				dout.cy <= -cvy_s2;
				dout.cz <= 32'h80000000;
			end else begin
				dout.cx <= cvx_s2;
				dout.cy <= cvy_s2;
				dout.cz <= 32'h00000000;
			end
			dout.cw <= cw_s2;
			dout.n  <= n_s2;
		end
	end

endmodule

### sv/asc_cell.sv
// One rotation cell: a single vectoring step on the pixel and corner lanes.
module asc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [4:0]         step,
	input  asc_pkg::asc_word_t din,
	output asc_pkg::asc_word_t dout
);
	import asc_pkg::*;

	asc_word_t  nxt;
	logic [31:0] at;

	always_comb begin
		nxt = din;
		at  = asc_atan(step);
		// hold a lane once its y has reached zero
		if (din.py != 0) begin
			if (din.py > 0) begin
				nxt.px = din.px + (din.py >>> step);
				nxt.py = din.py - (din.px >>> step);
				nxt.pz = din.pz + at;
			end else begin
				nxt.px = din.px - (din.py >>> step);
				nxt.py = din.py + (din.px >>> step);
				nxt.pz = din.pz - at;
			end
		end
		if (din.cy != 0) begin
			if (din.cy > 0) begin
				nxt.cx = din.cx + (din.cy >>> step);
				nxt.cy = din.cy - (din.cx >>> step);
				nxt.cz = din.cz + at;
			end else begin
				nxt.cx = din.cx - (din.cy >>> step);
				nxt.cy = din.cy + (din.cx >>> step);
				nxt.cz = din.cz - at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

### sv/asc_back.sv
// Back end: angle difference, segment number, colour lookup and output register.
module asc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  asc_pkg::asc_word_t din,
	output logic               out_valid,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         alpha,
	output logic [11:0]        segment_index
);
	import asc_pkg::*;

	logic [31:0]        zp, zc;
	logic [15:0]        qp, qc;
	logic signed [17:0] ap, ac, d;

	logic               vld_s1, vld_s2;
	logic [16:0]        d_s1;
	logic [10:0]        n_s1;
	logic [28:0]        prod;
	logic [11:0]        seg_s2;
	logic [6:0]         sm;
	logic [23:0]        rgb;

	always_comb begin
		zp = din.pz + 32'h00008000;
		zc = din.cz + 32'h00008000;
		qp = zp[31:16];
		qc = zc[31:16];
		ap = (qp > 16'h8000) ? $signed({2'b00, qp}) - 18'sd65536 : $signed({2'b00, qp});
		ac = (qc > 16'h8000) ? $signed({2'b00, qc}) - 18'sd65536 : $signed({2'b00, qc});
		d  = ap - ac;
		if (!din.cw) d = -d;
		if (d < 0) d = d + 18'sd65536;
		if (d > 18'sd65536) d = d - 18'sd65536;
	end

	always_comb begin
		prod = 29'(d_s1) * 29'({n_s1, 1'b0});
		// 64 is one more than 63: fold the high digits onto the low ones
		sm = {1'b0, seg_s2[11:6]} + {1'b0, seg_s2[5:0]};
		if (sm >= 7'd63) sm = sm - 7'd63;
		rgb = asc_palette(sm[5:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= din.vld;
			vld_s2    <= vld_s1;
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1          <= 17'(d);
			n_s1          <= din.n;
			seg_s2        <= prod[27:16];
			red           <= rgb[23:16];
			green         <= rgb[15:8];
			blue          <= rgb[7:0];
			segment_index <= seg_s2;
		end
	end

	assign alpha = 8'hFF;

endmodule

### sv/angular_segment_colour_map.sv
// Angular segment colour map: top level with configuration registers.
//
// Input channel in_valid/in_ready carries one pixel word (pixel_x, pixel_y).
// Output channel out_valid/out_ready carries one colour word (red, green,
// blue, alpha, segment_index) for every pixel, in order.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle; write only while no pixel is in flight. Index 7 is ignored.
// The datapath is a 36-stage pipeline: scaling, a fold stage, a row of 30
// vectoring cells (one rotation step each) and the segment and colour stages.
// One pixel per cycle is taken while the output side keeps up.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls, every stage holds and in_ready drops.
// Reset empties the pipeline and loads the register defaults: origin at the
// frame centre, 16 segments per half turn, clockwise, bottom-right corner, 640 x 480.
module angular_segment_colour_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [11:0] segment_index,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import asc_pkg::*;

	asc_cfg_t  cfg_q;
	asc_word_t chain [CORDIC_STEPS+1];
	logic      en;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_x     <= 17'd32768;
			cfg_q.centre_y     <= 17'd32768;
			cfg_q.segmentation <= 11'd16;
			cfg_q.clockwise    <= 1'b1;
			cfg_q.corner_pick  <= 3'd2;
			cfg_q.frame_width  <= 13'd640;
			cfg_q.frame_height <= 13'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:  cfg_q.centre_x     <= cfg_data;
				REG_ORIGIN_Y:  cfg_q.centre_y     <= cfg_data;
				REG_SEGMENTS:  cfg_q.segmentation <= cfg_data[10:0];
				REG_CLOCKWISE: cfg_q.clockwise    <= cfg_data[0];
				REG_CORNER:    cfg_q.corner_pick  <= cfg_data[2:0];
				REG_WIDTH:     cfg_q.frame_width  <= cfg_data[12:0];
				REG_HEIGHT:    cfg_q.frame_height <= cfg_data[12:0];
				default:       ;
			endcase
		end
	end

	asc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.cfg      (cfg_q),
		.dout     (chain[0])
	);

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		asc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (5'(g)),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	asc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.din           (chain[CORDIC_STEPS]),
		.out_valid     (out_valid),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.segment_index (segment_index)
	);

endmodule

### sv/asc_checker.sv
// Port-level checks of the angular segment colour map, bound to the top level.
`include "angular_segment_colour_map_macros.svh"

module asc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [11:0] segment_index
);

	`ASC_ASSERT_NOW(a_alpha_full, out_valid, alpha == 8'hFF, "alpha not opaque")
	`ASC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(segment_index) && $stable(red), "stalled word changed")
	`ASC_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input blocked with output empty")
	`ASC_ASSERT_NOW(a_first_colour, out_valid && segment_index == 12'd0,
		red == 8'h00 && green == 8'hFF && blue == 8'h00, "segment zero colour wrong")

endmodule

bind angular_segment_colour_map asc_checker u_asc_checker (.*);
